>>> sv/mf3_pkg.sv
// Shared types and constants for the 3x3 median filter with threshold count.
// No dependencies; imported by mf3_median and median_3x3_threshold_count.
`default_nettype none
package mf3_pkg;

	localparam int PIX_W      = 8;
	localparam int DIM_W      = 7;
	localparam int THR_W      = 9;
	localparam int CNT_W      = 12;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 9;
	localparam int OUT_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 2'd2;

	localparam logic [DIM_W-1:0] RST_FRAME_WIDTH  = 7'd64;
	localparam logic [DIM_W-1:0] RST_FRAME_HEIGHT = 7'd64;
	localparam logic [THR_W-1:0] RST_THRESHOLD    = 9'd0;

	typedef logic [PIX_W-1:0] pix_t;
	typedef pix_t [8:0] win_t;

	// sideband that rides along the sorting pipeline
	typedef struct packed {
		logic valid;
		logic last;
	} mf3_tag_t;

endpackage
`default_nettype wire

>>> sv/mf3_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Read data holds when no read is issued. No dependencies.
`default_nettype none
module mf3_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

>>> sv/mf3_median.sv
// Pipelined 19-exchange median-of-nine network, two register stages.
// Depends on mf3_pkg.
`default_nettype none
module mf3_median (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             en,
	input  wire mf3_pkg::mf3_tag_t tag_i,
	input  wire mf3_pkg::win_t    win_i,
	output mf3_pkg::mf3_tag_t     tag_o,
	output mf3_pkg::pix_t         med_o
);
	import mf3_pkg::*;

	function automatic pix_t mn(input pix_t a, input pix_t b);
		return (a < b) ? a : b;
	endfunction

	function automatic pix_t mx(input pix_t a, input pix_t b);
		return (a < b) ? b : a;
	endfunction

	win_t     a, b;
	win_t     a_s2, b_s3;
	mf3_tag_t tag_s2, tag_s3;
	pix_t     x4, x2, y4;

	// stage A: sort each group of three
	always_comb begin
		a = win_i;
		{a[1], a[2]} = {mn(a[1], a[2]), mx(a[1], a[2])};
		{a[4], a[5]} = {mn(a[4], a[5]), mx(a[4], a[5])};
		{a[7], a[8]} = {mn(a[7], a[8]), mx(a[7], a[8])};
		{a[0], a[1]} = {mn(a[0], a[1]), mx(a[0], a[1])};
		{a[3], a[4]} = {mn(a[3], a[4]), mx(a[3], a[4])};
		{a[6], a[7]} = {mn(a[6], a[7]), mx(a[6], a[7])};
		{a[1], a[2]} = {mn(a[1], a[2]), mx(a[1], a[2])};
		{a[4], a[5]} = {mn(a[4], a[5]), mx(a[4], a[5])};
		{a[7], a[8]} = {mn(a[7], a[8]), mx(a[7], a[8])};
	end

	// stage B: column maxima/minima and middle candidates
	always_comb begin
		b = a_s2;
		{b[0], b[3]} = {mn(b[0], b[3]), mx(b[0], b[3])};
		{b[5], b[8]} = {mn(b[5], b[8]), mx(b[5], b[8])};
		{b[4], b[7]} = {mn(b[4], b[7]), mx(b[4], b[7])};
		{b[3], b[6]} = {mn(b[3], b[6]), mx(b[3], b[6])};
		{b[1], b[4]} = {mn(b[1], b[4]), mx(b[1], b[4])};
		{b[2], b[5]} = {mn(b[2], b[5]), mx(b[2], b[5])};
		{b[4], b[7]} = {mn(b[4], b[7]), mx(b[4], b[7])};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
			tag_s3 <= '0;
		end else if (en) begin
			tag_s2 <= tag_i;
			tag_s3 <= tag_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s2 <= a;
			b_s3 <= b;
		end
	end

	// final three exchanges on the remaining candidates
	assign x4    = mn(b_s3[4], b_s3[2]);
	assign x2    = mx(b_s3[4], b_s3[2]);
	assign y4    = mx(b_s3[6], x4);
	assign med_o = mn(y4, x2);
	assign tag_o = tag_s3;

endmodule
`default_nettype wire

>>> sv/median_3x3_threshold_count.sv
// 3x3 median filter with threshold flag and per-frame running count.
// Each result passes the line store read, two sorting stages and the output register.
// Accepts one pixel per cycle, set by the single read and write port of each line
// store RAM; a held result stalls all.
// Reset: positions, window and count clear; size 64x64, threshold 0.
// Line stores are not cleared; rows above the first windows are written first.
`default_nettype none
module median_3x3_threshold_count #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	input  wire logic [7:0]                      s_tdata,  // [7:0] pixel
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// [7:0] median, [8] at_or_above, [20:9] count_so_far, [23:21] zero
	output logic [mf3_pkg::OUT_DATA_W-1:0]       m_tdata,
	output logic                                 m_tlast,  // last_window
	input  wire logic                            cfg_we,
	input  wire logic [mf3_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [mf3_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import mf3_pkg::*;

	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int RW  = $clog2(MAX_HEIGHT);
	localparam int WW  = ($clog2(MAX_WIDTH + 1) > DIM_W) ? $clog2(MAX_WIDTH + 1) : DIM_W;
	localparam int HW  = ($clog2(MAX_HEIGHT + 1) > DIM_W) ? $clog2(MAX_HEIGHT + 1) : DIM_W;
	localparam int PAD = OUT_DATA_W - PIX_W - 1 - CNT_W;

	logic [DIM_W-1:0] width_q, height_q;
	logic [THR_W-1:0] thr_q;
	logic [WW-1:0]    w_eff;
	logic [HW-1:0]    h_eff;
	logic             restart;

	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic          col_end, row_end, acc, adv;

	logic          v_s1, emit_s1, last_s1, fwd_s1;
	pix_t          pix_s1, fwd_top_s1, fwd_mid_s1, top_s1, mid_s1;
	logic [CW-1:0] col_s1;
	pix_t          up_rdata, lo_rdata;
	logic          wr_s1;

	pix_t [5:0] wc_q;
	win_t       win_s1;
	mf3_tag_t   tag_in, tag_s3;
	pix_t       med_s3;

	logic [CNT_W-1:0] cnt_q, cnt_next;
	logic             at_s3;
	logic             m_tvalid_q, m_tlast_q, at_q;
	pix_t             med_q;
	logic [CNT_W-1:0] cnt_out_q;

	// ---------------- configuration ----------------
	assign restart = cfg_we && (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RST_FRAME_WIDTH;
			height_q <= RST_FRAME_HEIGHT;
			thr_q    <= RST_THRESHOLD;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FRAME_WIDTH:  width_q  <= cfg_data[DIM_W-1:0];
				REG_FRAME_HEIGHT: height_q <= cfg_data[DIM_W-1:0];
				REG_THRESHOLD:    thr_q    <= cfg_data[THR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (width_q == '0) begin
			w_eff = WW'(1);
		end else if (WW'(width_q) > WW'(MAX_WIDTH)) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(width_q);
		end
		if (height_q == '0) begin
			h_eff = HW'(1);
		end else if (HW'(height_q) > HW'(MAX_HEIGHT)) begin
			h_eff = HW'(MAX_HEIGHT);
		end else begin
			h_eff = HW'(height_q);
		end
	end

	// ---------------- input and raster position ----------------
	assign adv      = !m_tvalid_q || m_tready;
	assign s_tready = adv;
	assign acc      = s_tvalid && adv;
	assign col_end  = (WW'(col_q) + WW'(1)) >= w_eff;
	assign row_end  = (HW'(row_q) + HW'(1)) >= h_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (restart) begin
			col_q <= '0;
			row_q <= '0;
		end else if (acc) begin
			if (col_end) begin
				col_q <= '0;
				row_q <= row_end ? '0 : row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// ---------------- line stores: read on accept, write back in s1 ----------------
	assign wr_s1 = adv && v_s1;

	mf3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
		.clk   (clk),
		.we    (wr_s1),
		.waddr (col_s1),
		.wdata (mid_s1),
		.re    (acc),
		.raddr (col_q),
		.rdata (up_rdata)
	);

	mf3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_lower (
		.clk   (clk),
		.we    (wr_s1),
		.waddr (col_s1),
		.wdata (pix_s1),
		.re    (acc),
		.raddr (col_q),
		.rdata (lo_rdata)
	);

	// a read that meets a write to the same column takes the written values
	assign top_s1 = fwd_s1 ? fwd_top_s1 : up_rdata;
	assign mid_s1 = fwd_s1 ? fwd_mid_s1 : lo_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			fwd_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= acc;
			if (acc) begin
				fwd_s1 <= v_s1 && (col_s1 == col_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			pix_s1     <= s_tdata;
			col_s1     <= col_q;
			emit_s1    <= (col_q >= CW'(2)) && (row_q >= RW'(2));
			last_s1    <= col_end && row_end;
			fwd_top_s1 <= mid_s1;
			fwd_mid_s1 <= pix_s1;
		end
	end

	// ---------------- window columns ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wc_q <= '0;
		end else if (wr_s1) begin
			wc_q <= {pix_s1, mid_s1, top_s1, wc_q[5], wc_q[4], wc_q[3]};
		end
	end

	assign win_s1       = {pix_s1, mid_s1, top_s1, wc_q};
	assign tag_in.valid = v_s1 && emit_s1;
	assign tag_in.last  = last_s1;

	mf3_median u_median (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.tag_i  (tag_in),
		.win_i  (win_s1),
		.tag_o  (tag_s3),
		.med_o  (med_s3)
	);

	// ---------------- threshold, count, output register ----------------
	assign at_s3    = {1'b0, med_s3} >= thr_q;
	assign cnt_next = cnt_q + CNT_W'(at_s3 && (cnt_q != '1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
			cnt_q      <= '0;
		end else if (restart) begin
			cnt_q <= '0;
		end else if (adv) begin
			m_tvalid_q <= tag_s3.valid;
			if (tag_s3.valid) begin
				cnt_q <= tag_s3.last ? '0 : cnt_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && tag_s3.valid) begin
			med_q     <= med_s3;
			at_q      <= at_s3;
			cnt_out_q <= cnt_next;
			m_tlast_q <= tag_s3.last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tlast  = m_tlast_q;
	assign m_tdata  = {{PAD{1'b0}}, cnt_out_q, at_q, med_q};

endmodule
`default_nettype wire

>>> dv/median_3x3_threshold_count_checker.sv
`timescale 1ns / 1ps
// Result checker for median_3x3_threshold_count: follows register writes and
// accepted pixels, predicts each window result and compares the output stream.
// Depends on mf3_pkg.
module median_3x3_threshold_count_checker #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	input  wire logic                            s_tready,
	input  wire logic [7:0]                      s_tdata,  // [7:0] pixel
	input  wire logic                            m_tvalid,
	input  wire logic                            m_tready,
	// [7:0] median, [8] at_or_above, [20:9] count_so_far, [23:21] zero
	input  wire logic [mf3_pkg::OUT_DATA_W-1:0]  m_tdata,
	input  wire logic                            m_tlast,  // last_window
	input  wire logic                            cfg_we,
	input  wire logic [mf3_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [mf3_pkg::CFG_DATA_W-1:0]  cfg_data,
	output int                                   errors,
	output int                                   pending
);
	import mf3_pkg::*;

	typedef struct packed {
		pix_t             median;
		logic             at_or_above;
		logic [CNT_W-1:0] count;
		logic             last;
	} window_result_t;

	pix_t             line_upper [MAX_WIDTH];
	pix_t             line_lower [MAX_WIDTH];
	pix_t             prev_cols [6];
	int               col_pos;
	int               row_pos;
	logic [CNT_W-1:0] hit_count;
	logic [DIM_W-1:0] width_reg;
	logic [DIM_W-1:0] height_reg;
	logic [THR_W-1:0] thr_reg;
	window_result_t   expected_windows [$];
	int               err_count = 0;

	function automatic int clamp_dim(logic [DIM_W-1:0] v, int hi);
		if (v < 1)
			return 1;
		if (v > hi)
			return hi;
		return v;
	endfunction

	// value with at most four smaller and at least five smaller-or-equal
	function automatic pix_t median_nine(win_t w);
		int below;
		int equal;
		median_nine = w[0];
		for (int i = 0; i < 9; i++) begin
			below = 0;
			equal = 0;
			for (int j = 0; j < 9; j++) begin
				if (w[j] < w[i])
					below++;
				else if (w[j] == w[i])
					equal++;
			end
			if (below <= 4 && below + equal >= 5)
				median_nine = w[i];
		end
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t: %s mismatch, got %0d, expected %0d", $time, what, got, want);
		err_count++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		case (idx)
			REG_FRAME_WIDTH: begin
				width_reg = value[DIM_W-1:0];
				col_pos = 0;
				row_pos = 0;
				hit_count = '0;
			end
			REG_FRAME_HEIGHT: begin
				height_reg = value[DIM_W-1:0];
				col_pos = 0;
				row_pos = 0;
				hit_count = '0;
			end
			REG_THRESHOLD: begin
				thr_reg = value[THR_W-1:0];
			end
			default: ;
		endcase
	endtask

	task automatic predict_window(input pix_t p);
		int             w_eff;
		int             h_eff;
		pix_t           top_px;
		pix_t           mid_px;
		win_t           win;
		window_result_t res;
		w_eff = clamp_dim(width_reg, MAX_WIDTH);
		h_eff = clamp_dim(height_reg, MAX_HEIGHT);
		top_px = line_upper[col_pos];
		mid_px = line_lower[col_pos];
		line_upper[col_pos] = mid_px;
		line_lower[col_pos] = p;
		if (row_pos >= 2 && col_pos >= 2) begin
			for (int i = 0; i < 6; i++)
				win[i] = prev_cols[i];
			win[6] = top_px;
			win[7] = mid_px;
			win[8] = p;
			res.median = median_nine(win);
			res.at_or_above = ({1'b0, res.median} >= thr_reg);
			if (res.at_or_above && hit_count != '1)
				hit_count++;
			res.count = hit_count;
			res.last = (row_pos + 1 >= h_eff) && (col_pos + 1 >= w_eff);
			expected_windows.push_back(res);
			if (res.last)
				hit_count = '0;
		end
		for (int i = 0; i < 3; i++)
			prev_cols[i] = prev_cols[i + 3];
		prev_cols[3] = top_px;
		prev_cols[4] = mid_px;
		prev_cols[5] = p;
		if (col_pos + 1 >= w_eff) begin
			col_pos = 0;
			row_pos = (row_pos + 1 >= h_eff) ? 0 : row_pos + 1;
		end else begin
			col_pos++;
		end
	endtask

	task automatic check_result();
		window_result_t want;
		if (expected_windows.size() == 0) begin
			report_mismatch("unrequested result, median", m_tdata[PIX_W-1:0], 0);
		end else begin
			want = expected_windows.pop_front();
			if (m_tdata[PIX_W-1:0] !== want.median)
				report_mismatch("median", m_tdata[PIX_W-1:0], want.median);
			if (m_tdata[PIX_W] !== want.at_or_above)
				report_mismatch("at_or_above", m_tdata[PIX_W], want.at_or_above);
			if (m_tdata[PIX_W+CNT_W:PIX_W+1] !== want.count)
				report_mismatch("count_so_far", m_tdata[PIX_W+CNT_W:PIX_W+1], want.count);
			if (m_tlast !== want.last)
				report_mismatch("last_window", m_tlast, want.last);
			if (m_tdata[OUT_DATA_W-1:PIX_W+CNT_W+1] !== '0)
				report_mismatch("pad bits", m_tdata[OUT_DATA_W-1:PIX_W+CNT_W+1], 0);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_reg = RST_FRAME_WIDTH;
			height_reg = RST_FRAME_HEIGHT;
			thr_reg = RST_THRESHOLD;
			for (int i = 0; i < MAX_WIDTH; i++) begin
				line_upper[i] = '0;
				line_lower[i] = '0;
			end
			for (int i = 0; i < 6; i++)
				prev_cols[i] = '0;
			col_pos = 0;
			row_pos = 0;
			hit_count = '0;
			expected_windows.delete();
		end else begin
			if (cfg_we)
				write_reg(cfg_index, cfg_data);
			if (s_tvalid && s_tready)
				predict_window(s_tdata);
			if (m_tvalid && m_tready)
				check_result();
		end
		errors <= err_count;
		pending <= expected_windows.size();
	end

endmodule

>>> dv/tb_median_3x3_threshold_count.sv
`timescale 1ns / 1ps
// Testbench top for median_3x3_threshold_count: drives pixel frames and register
// writes under varied idling, stalls the result side, and gives the verdict.
// Depends on mf3_pkg, the block and median_3x3_threshold_count_checker.
module tb_median_3x3_threshold_count;
	import mf3_pkg::*;

	localparam int MAX_DIM       = 64;
	localparam int ITEM_TARGET   = 1700;
	localparam int STALL_LIMIT   = 2000;
	localparam int HOLD_LEN      = 300;
	localparam int SETTLE_CYCLES = 12;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [7:0]            s_tdata = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tlast;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_FRAME_WIDTH;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	int errors;
	int pending;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_token = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int quiet_cycles = 0;
	int items_sent = 0;
	int thr_now = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	median_3x3_threshold_count dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	median_3x3_threshold_count_checker window_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.errors    (errors),
		.pending   (pending)
	);

	// result side: random stalls, plus a long hold-off on request
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_token != hold_seen) begin
			hold_seen <= hold_token;
			hold_left <= HOLD_LEN;
			m_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("tb_median_3x3_threshold_count: done, errors");
				$finish;
			end
		end
	end

	function automatic int eff_dim(int v);
		if (v < 1)
			return 1;
		if (v > MAX_DIM)
			return MAX_DIM;
		return v;
	endfunction

	function automatic int pick_dim();
		case ($urandom_range(0, 15))
			0: return 0;
			1: return 127;
			2: return 64;
			3: return $urandom_range(1, 2);
			4: return $urandom_range(65, 126);
			default: return $urandom_range(3, 10);
		endcase
	endfunction

	function automatic int pick_threshold();
		case ($urandom_range(0, 9))
			0: return 0;
			1: return 255;
			2: return $urandom_range(256, 511);
			3: return 511;
			default: return $urandom_range(1, 254);
		endcase
	endfunction

	function automatic pix_t gen_pixel(int style);
		int base;
		int v;
		case (style)
			1: begin
				// cluster around the threshold so the flag flips both ways
				base = (thr_now > 255) ? 255 : thr_now;
				v = base + $urandom_range(0, 6) - 3;
				if (v < 0)
					v = 0;
				if (v > 255)
					v = 255;
				return pix_t'(v);
			end
			2: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
			3: return pix_t'($urandom_range(96, 159));
			default: return pix_t'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[CFG_DATA_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_pixel(input pix_t p);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= p;
		do
			@(posedge clk);
		while (!s_tready);
		items_sent++;
	endtask

	task automatic send_run(input int n, input int style, input logic hold);
		for (int k = 0; k < n; k++) begin
			if (hold && k == 0)
				hold_token <= hold_token + 1;
			send_pixel(gen_pixel(style));
		end
	endtask

	// wait for every window result, then for items that make none
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		pix_t first_frame [9];
		int   phase;
		int   w_set;
		int   h_set;
		int   w_eff;
		int   h_eff;
		int   n;
		logic hold;
		first_frame = '{8'h00, 8'hFF, 8'h80, 8'hFF, 8'h00, 8'h7F, 8'h01, 8'hFE, 8'h80};
		w_set = 3;
		h_set = 3;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// one 3x3 frame: a single window with extreme pixels
		write_reg(REG_FRAME_WIDTH, 3);
		write_reg(REG_FRAME_HEIGHT, 3);
		write_reg(REG_THRESHOLD, 0);
		thr_now = 0;
		foreach (first_frame[i])
			send_pixel(first_frame[i]);
		settle();

		// unused index ignored; threshold 256 counts nothing; 3x4 frame
		write_reg(REG_UNUSED, 9'h1FF);
		write_reg(REG_THRESHOLD, 256);
		thr_now = 256;
		write_reg(REG_FRAME_WIDTH, 3);
		write_reg(REG_FRAME_HEIGHT, 4);
		send_run(12, 2, 1'b0);
		settle();

		// width 0 clamps to 1: no window fits
		write_reg(REG_FRAME_WIDTH, 0);
		write_reg(REG_FRAME_HEIGHT, 127);
		w_set = 0;
		h_set = 127;
		send_run(3, 0, 1'b0);
		settle();

		phase = 0;
		while (items_sent < ITEM_TARGET) begin
			case (phase % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 71; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 71; end
				default: begin send_idle_pct = 14; stall_pct = 14; end
			endcase
			hold = (phase % 5 == 2);

			thr_now = pick_threshold();
			if (phase % 4 != 0 && $urandom_range(0, 3) == 0 && !hold) begin
				// threshold alone: the frame in progress carries on
				write_reg(REG_THRESHOLD, thr_now);
			end else begin
				w_set = pick_dim();
				h_set = pick_dim();
				if (hold) begin
					w_set = $urandom_range(3, 8);
					h_set = $urandom_range(3, 8);
				end else if (eff_dim(w_set) > 10 && eff_dim(h_set) > 4) begin
					h_set = $urandom_range(3, 4);
				end else if (eff_dim(h_set) > 10 && eff_dim(w_set) > 4) begin
					w_set = $urandom_range(3, 4);
				end
				write_reg(REG_FRAME_WIDTH, w_set);
				write_reg(REG_FRAME_HEIGHT, h_set);
				write_reg(REG_THRESHOLD, thr_now);
				if ($urandom_range(0, 7) == 0)
					write_reg(REG_UNUSED, $urandom_range(0, 511));
			end
			w_eff = eff_dim(w_set);
			h_eff = eff_dim(h_set);

			if (w_eff < 3 || h_eff < 3) begin
				n = $urandom_range(10, 40);
			end else begin
				n = w_eff * h_eff;
				if (n <= 100)
					n = n * $urandom_range(1, 3);
				// sometimes stop mid-frame
				if ($urandom_range(0, 1))
					n += $urandom_range(1, 2 * w_eff);
			end
			send_run(n, $urandom_range(0, 3), hold);
			settle();
			phase++;
		end

		if (errors == 0 && pending == 0)
			$display("tb_median_3x3_threshold_count: done, clean");
		else
			$display("tb_median_3x3_threshold_count: done, errors");
		$finish;
	end

endmodule
